[rtl/pcapdf_pkg.sv]
`default_nettype none

package pcapdf_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned POS_W = 5;

    localparam logic [WORD_W-1:0] MAGIC_NATIVE = 32'ha1b2c3d4;
    localparam logic [WORD_W-1:0] MAGIC_SWAPPED = 32'hd4c3b2a1;

    // last byte of the magic word and of the global header, and record header word ends
    localparam logic [POS_W-1:0] POS_MAGIC_END = 5'd3;
    localparam logic [POS_W-1:0] POS_GLOBAL_END = 5'd23;
    localparam logic [POS_W-1:0] POS_SECONDS_END = 5'd3;
    localparam logic [POS_W-1:0] POS_MICRO_END = 5'd7;
    localparam logic [POS_W-1:0] POS_INCL_END = 5'd11;

    typedef enum logic [2:0] {
        PH_GLOBAL   = 3'd0,
        PH_RECORD   = 3'd1,
        PH_PAYLOAD  = 3'd2,
        PH_STOPPED  = 3'd3,
        PH_BADMAGIC = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_META     = 2'd1,
        KIND_BADMAGIC = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t              result_kind;
        logic [WORD_W-1:0]  ts_seconds;
        logic [WORD_W-1:0]  ts_micro;
        logic [WORD_W-1:0]  included_length;
        logic [WORD_W-1:0]  original_length;
        logic [BYTE_W-1:0]  payload_byte;
        logic               last_of_packet;
        logic [WORD_W-1:0]  packet_count;
        logic [WORD_W-1:0]  byte_total;
    } result_t;

endpackage

`default_nettype wire

[rtl/pcapdf_in_reg.sv]
`default_nettype none

module pcapdf_in_reg
    import pcapdf_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [BYTE_W-1:0] s_byte,
    input  wire logic              down_ready,
    output logic                   byte_valid,
    output logic [BYTE_W-1:0]      byte_data,
    output logic                   advance
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;

    assign advance    = valid_reg && down_ready;
    assign s_tready   = !valid_reg || down_ready;
    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_byte;
        end
    end

endmodule

`default_nettype wire

[rtl/pcapdf_parser.sv]
`default_nettype none

module pcapdf_parser
    import pcapdf_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_valid,
    input  wire logic [WORD_W-1:0] cfg_data,
    input  wire logic              advance,
    input  wire logic [BYTE_W-1:0] in_byte,
    output logic                   res_valid,
    output result_t                res
);

    phase_t            phase_reg, phase_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              swapped_reg, swapped_next;
    logic [WORD_W-1:0] shift_reg, shift_next;
    logic [WORD_W-1:0] seconds_reg, seconds_next;
    logic [WORD_W-1:0] micro_reg, micro_next;
    logic [WORD_W-1:0] incl_reg, incl_next;
    logic [WORD_W-1:0] remain_reg, remain_next;
    logic [WORD_W-1:0] pkt_reg, pkt_next;
    logic [WORD_W-1:0] bytes_reg, bytes_next;
    logic [WORD_W-1:0] max_packets_reg;

    logic [WORD_W-1:0] shifted;
    logic [WORD_W-1:0] word_fixed;
    logic [WORD_W-1:0] pkt_inc;
    logic [WORD_W-1:0] bytes_sum;
    logic              word_end;
    logic              incl_zero;
    logic              remain_last;
    logic              limit_hit;
    logic              magic_native;
    logic              magic_swapped;

    assign shifted       = {in_byte, shift_reg[WORD_W-1:BYTE_W]};
    assign word_fixed    = swapped_reg ? {shifted[7:0], shifted[15:8], shifted[23:16],
                                          shifted[31:24]} : shifted;
    assign pkt_inc       = pkt_reg + 32'd1;
    assign bytes_sum     = bytes_reg + incl_reg;
    assign word_end      = (pos_reg[1:0] == 2'd3);
    assign incl_zero     = (incl_reg == '0);
    assign remain_last   = (remain_reg <= 32'd1);
    assign magic_native  = (shifted == MAGIC_NATIVE);
    assign magic_swapped = (shifted == MAGIC_SWAPPED);
    // a header packet completes after the tally increments; a payload one already has
    assign limit_hit     = (max_packets_reg != '0) &&
                           (((phase_reg == PH_RECORD) ? pkt_inc : pkt_reg) >= max_packets_reg);

    // next state
    always_comb begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        swapped_next = swapped_reg;
        shift_next   = shift_reg;
        seconds_next = seconds_reg;
        micro_next   = micro_reg;
        incl_next    = incl_reg;
        remain_next  = remain_reg;
        pkt_next     = pkt_reg;
        bytes_next   = bytes_reg;
        case (phase_reg)
            PH_GLOBAL: begin
                if (pos_reg < 5'd4) begin
                    shift_next = shifted;
                end
                if (pos_reg == POS_MAGIC_END && !magic_native && !magic_swapped) begin
                    phase_next = PH_BADMAGIC;
                    pos_next   = '0;
                end else begin
                    if (pos_reg == POS_MAGIC_END) begin
                        swapped_next = magic_swapped;
                    end
                    if (pos_reg >= POS_GLOBAL_END) begin
                        phase_next = PH_RECORD;
                        pos_next   = '0;
                    end else begin
                        pos_next = pos_reg + 5'd1;
                    end
                end
            end
            PH_RECORD: begin
                shift_next = shifted;
                if (!word_end || pos_reg == POS_SECONDS_END || pos_reg == POS_MICRO_END ||
                    pos_reg == POS_INCL_END) begin
                    pos_next = pos_reg + 5'd1;
                    if (pos_reg == POS_SECONDS_END) begin
                        seconds_next = word_fixed;
                    end
                    if (pos_reg == POS_MICRO_END) begin
                        micro_next = word_fixed;
                    end
                    if (pos_reg == POS_INCL_END) begin
                        incl_next = word_fixed;
                    end
                end else begin
                    pkt_next   = pkt_inc;
                    bytes_next = bytes_sum;
                    pos_next   = '0;
                    if (incl_zero) begin
                        phase_next = limit_hit ? PH_STOPPED : PH_RECORD;
                    end else begin
                        remain_next = incl_reg;
                        phase_next  = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                if (remain_last) begin
                    remain_next = '0;
                    pos_next    = '0;
                    phase_next  = limit_hit ? PH_STOPPED : PH_RECORD;
                end else begin
                    remain_next = remain_reg - 32'd1;
                end
            end
            default: begin
                phase_next = phase_reg;
            end
        endcase
    end

    // result
    always_comb begin
        res_valid = 1'b0;
        res       = '0;
        case (phase_reg)
            PH_GLOBAL: begin
                if (pos_reg == POS_MAGIC_END && !magic_native && !magic_swapped) begin
                    res_valid       = 1'b1;
                    res.result_kind = KIND_BADMAGIC;
                end
            end
            PH_RECORD: begin
                if (word_end && pos_reg != POS_SECONDS_END && pos_reg != POS_MICRO_END &&
                    pos_reg != POS_INCL_END) begin
                    res_valid           = 1'b1;
                    res.result_kind     = KIND_META;
                    res.ts_seconds      = seconds_reg;
                    res.ts_micro        = micro_reg;
                    res.included_length = incl_reg;
                    res.original_length = word_fixed;
                    res.last_of_packet  = incl_zero;
                    res.packet_count    = pkt_inc;
                    res.byte_total      = bytes_sum;
                end
            end
            PH_PAYLOAD: begin
                res_valid          = 1'b1;
                res.result_kind    = KIND_PAYLOAD;
                res.payload_byte   = in_byte;
                res.last_of_packet = remain_last;
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_GLOBAL;
            pos_reg         <= '0;
            swapped_reg     <= 1'b0;
            shift_reg       <= '0;
            seconds_reg     <= '0;
            micro_reg       <= '0;
            incl_reg        <= '0;
            remain_reg      <= '0;
            pkt_reg         <= '0;
            bytes_reg       <= '0;
            max_packets_reg <= '0;
        end else begin
            if (advance) begin
                phase_reg   <= phase_next;
                pos_reg     <= pos_next;
                swapped_reg <= swapped_next;
                shift_reg   <= shift_next;
                seconds_reg <= seconds_next;
                micro_reg   <= micro_next;
                incl_reg    <= incl_next;
                remain_reg  <= remain_next;
                pkt_reg     <= pkt_next;
                bytes_reg   <= bytes_next;
            end
            if (cfg_valid) begin
                max_packets_reg <= cfg_data;
            end
        end
    end

    a_badmagic_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_BADMAGIC |=> phase_reg == PH_BADMAGIC)
        else $error("bad magic phase was left");

    a_stopped_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_STOPPED |=> phase_reg == PH_STOPPED)
        else $error("stopped phase was left");

    a_payload_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAYLOAD |-> remain_reg != '0)
        else $error("payload phase with nothing remaining");

    a_record_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_RECORD |-> pos_reg < 5'd16)
        else $error("record header position out of range");

endmodule

`default_nettype wire

[rtl/pcapdf_out_buf.sv]
`default_nettype none

module pcapdf_out_buf
    import pcapdf_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         up_ready,
    output logic         m_valid,
    input  wire logic    m_ready,
    output result_t      m_data
);

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign pop      = main_valid_reg && m_ready;
    assign up_ready = !skid_valid_reg;
    assign m_valid  = main_valid_reg;
    assign m_data   = main_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (!main_valid_reg || pop) begin
            // refill the head from the skid entry first
            if (skid_valid_reg) begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                main_next       = push_data;
                main_valid_next = push;
            end
        end else if (push) begin
            skid_next       = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held with empty head");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> !push)
        else $error("transaction pushed into a full buffer");

    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && pop |=> !skid_valid_reg)
        else $error("skid entry not moved on head pop");

endmodule

`default_nettype wire

[rtl/pcap_stream_deframer.sv]
`default_nettype none

// Byte-serial capture file deframer. One file byte enters per transaction on
// s_tdata; the global header selects byte order, each record header gives one
// metadata transaction (tuser = 1) and each payload byte one payload
// transaction (tuser = 0), with tlast on the last byte of a packet or on the
// metadata of an empty packet. A bad magic word gives one tuser = 2
// transaction and the block then drops all input until reset; input is also
// dropped once a nonzero max_packets limit is reached. Throughput is one byte
// per clock unless m_tready stalls the two-entry output buffer, set by the
// combinational parse step between the input register and that buffer.
// cfg_data sets max_packets and is always ready.
module pcap_stream_deframer
    import pcapdf_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [31:0]  cfg_data,      // max_packets
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,       // [7:0] data_byte
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [199:0]      m_tdata,       // ts_seconds, ts_micro, included_length,
                                             // original_length, payload_byte,
                                             // packet_count, byte_total
    output logic [1:0]        m_tuser,       // [1:0] result_kind
    output logic              m_tlast        // last_of_packet
);

    logic              down_ready;
    logic              byte_valid;
    logic [BYTE_W-1:0] byte_data;
    logic              advance;
    logic              res_valid;
    result_t           res;
    result_t           out_res;

    assign cfg_ready = 1'b1;

    pcapdf_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_byte     (s_tdata),
        .down_ready (down_ready),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .advance    (advance)
    );

    pcapdf_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .advance   (advance),
        .in_byte   (byte_data),
        .res_valid (res_valid),
        .res       (res)
    );

    pcapdf_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (advance && byte_valid && res_valid),
        .push_data (res),
        .up_ready  (down_ready),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_data    (out_res)
    );

    assign m_tuser = out_res.result_kind;
    assign m_tlast = out_res.last_of_packet;
    assign m_tdata = {out_res.byte_total, out_res.packet_count, out_res.payload_byte,
                      out_res.original_length, out_res.included_length,
                      out_res.ts_micro, out_res.ts_seconds};

endmodule

`default_nettype wire
